/* rtl/dgt_pkg.sv */
// dgt_pkg: shared types, byte constants and character-class functions for the
// digest directive tokenizer.
// No dependencies; used by dgt_parser and digest_directive_tokenizer.
package dgt_pkg;

    // Parser states
    typedef enum logic [2:0] {
        ST_SPACE  = 3'd0,  // expecting name, skipping white space
        ST_TOKEN  = 3'd1,  // inside a directive name
        ST_EQUALS = 3'd2,  // just after '='
        ST_VALUE  = 3'd3,  // inside an unquoted value
        ST_QUOTED = 3'd4,  // inside a quoted value
        ST_ESCAPE = 3'd5,  // after a backslash in a quoted value
        ST_COMMA  = 3'd6   // pair closed, expecting ','
    } dgt_state_t;

    // Role given to each byte
    typedef enum logic [1:0] {
        ROLE_SEP   = 2'd0,
        ROLE_NAME  = 2'd1,
        ROLE_VALUE = 2'd2,
        ROLE_ERR   = 2'd3
    } dgt_role_t;

    // Byte constants
    localparam logic [7:0] CH_EQUALS    = 8'h3D;  // '='
    localparam logic [7:0] CH_QUOTE     = 8'h22;  // '"'
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;  // '\'
    localparam logic [7:0] CH_COMMA     = 8'h2C;  // ','
    localparam logic [7:0] CH_UNDER     = 8'h5F;  // '_'
    localparam logic [7:0] CH_DASH      = 8'h2D;  // '-'
    localparam logic [7:0] CH_BLANK     = 8'h20;  // ' '

    // Prefix length after reset: "Digest" plus one space
    localparam logic [3:0] SKIP_RESET = 4'd7;

    // One result item
    typedef struct packed {
        dgt_role_t  role;
        logic [7:0] data;
        logic       pair_done;
        logic       header_done;
        logic       header_ok;
    } dgt_result_t;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
    endfunction

    // space, tab, LF, VT, FF, CR
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_BLANK) || (c inside {[8'h09:8'h0D]});
    endfunction

    function automatic logic is_name(input logic [7:0] c);
        return is_alnum(c) || (c == CH_UNDER) || (c == CH_DASH);
    endfunction

endpackage

/* rtl/dgt_parser.sv */
// dgt_parser: per-header parse state and the combinational byte classifier.
// Depends on dgt_pkg for state, role and result types and class functions.
module dgt_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,          // item moves to the result register
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  logic [3:0]          prefix_skip,
    output dgt_pkg::dgt_result_t res
);

    dgt_pkg::dgt_state_t state_reg, state_next;
    logic                error_seen_reg, error_seen_next;
    logic [3:0]          skip_left_reg, skip_left_next;

    dgt_pkg::dgt_role_t  role;
    logic                pair;
    logic                bad;
    logic                end_ok;

    // Byte classification and next state
    always_comb begin
        role            = dgt_pkg::ROLE_SEP;
        pair            = 1'b0;
        bad             = 1'b0;
        state_next      = state_reg;
        skip_left_next  = skip_left_reg;
        error_seen_next = error_seen_reg;

        if (error_seen_reg) begin
            role = dgt_pkg::ROLE_ERR;
        end else if (skip_left_reg != 4'd0) begin
            skip_left_next = skip_left_reg - 4'd1;
        end else begin
            case (state_reg)
                dgt_pkg::ST_SPACE: begin
                    if (dgt_pkg::is_name(in_byte)) begin
                        role       = dgt_pkg::ROLE_NAME;
                        state_next = dgt_pkg::ST_TOKEN;
                    end else if (!dgt_pkg::is_space(in_byte)) begin
                        bad = 1'b1;
                    end
                end
                dgt_pkg::ST_TOKEN: begin
                    if (in_byte == dgt_pkg::CH_EQUALS) begin
                        state_next = dgt_pkg::ST_EQUALS;
                    end else if (dgt_pkg::is_name(in_byte)) begin
                        role = dgt_pkg::ROLE_NAME;
                    end else begin
                        bad = 1'b1;
                    end
                end
                dgt_pkg::ST_EQUALS: begin
                    if (dgt_pkg::is_alnum(in_byte) || in_byte == dgt_pkg::CH_UNDER) begin
                        role       = dgt_pkg::ROLE_VALUE;
                        state_next = dgt_pkg::ST_VALUE;
                    end else if (in_byte == dgt_pkg::CH_QUOTE) begin
                        state_next = dgt_pkg::ST_QUOTED;
                    end else begin
                        bad = 1'b1;
                    end
                end
                dgt_pkg::ST_QUOTED: begin
                    if (in_byte == dgt_pkg::CH_BACKSLASH) begin
                        state_next = dgt_pkg::ST_ESCAPE;
                    end else if (in_byte == dgt_pkg::CH_QUOTE) begin
                        pair       = 1'b1;
                        state_next = dgt_pkg::ST_COMMA;
                    end else begin
                        role = dgt_pkg::ROLE_VALUE;
                    end
                end
                dgt_pkg::ST_ESCAPE: begin
                    // escaped byte is kept, the backslash was dropped
                    role       = dgt_pkg::ROLE_VALUE;
                    state_next = dgt_pkg::ST_QUOTED;
                end
                dgt_pkg::ST_VALUE: begin
                    if (dgt_pkg::is_space(in_byte)) begin
                        pair       = 1'b1;
                        state_next = dgt_pkg::ST_COMMA;
                    end else if (in_byte == dgt_pkg::CH_COMMA) begin
                        pair       = 1'b1;
                        state_next = dgt_pkg::ST_SPACE;
                    end else begin
                        role = dgt_pkg::ROLE_VALUE;
                    end
                end
                dgt_pkg::ST_COMMA: begin
                    if (in_byte == dgt_pkg::CH_COMMA) begin
                        state_next = dgt_pkg::ST_SPACE;
                    end else if (!dgt_pkg::is_space(in_byte)) begin
                        bad = 1'b1;
                    end
                end
                default: begin
                    bad = 1'b1;
                end
            endcase
            if (bad) begin
                error_seen_next = 1'b1;
                role            = dgt_pkg::ROLE_ERR;
            end
        end

        // End-of-header verdict; an open unquoted value is closed here
        end_ok = !error_seen_next && (skip_left_next == 4'd0) &&
                 (state_next == dgt_pkg::ST_VALUE || state_next == dgt_pkg::ST_COMMA);
        if (in_last && end_ok && state_next == dgt_pkg::ST_VALUE) begin
            pair = 1'b1;
        end

        res.role        = role;
        res.data        = (role == dgt_pkg::ROLE_NAME || role == dgt_pkg::ROLE_VALUE) ?
                          in_byte : 8'd0;
        res.pair_done   = pair;
        res.header_done = in_last;
        res.header_ok   = in_last && end_ok;
    end

    // Parse state; the last byte restarts for the next header
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= dgt_pkg::ST_SPACE;
            error_seen_reg <= 1'b0;
            skip_left_reg  <= dgt_pkg::SKIP_RESET;
        end else if (adv) begin
            if (in_last) begin
                state_reg      <= dgt_pkg::ST_SPACE;
                error_seen_reg <= 1'b0;
                skip_left_reg  <= prefix_skip;
            end else begin
                state_reg      <= state_next;
                error_seen_reg <= error_seen_next;
                skip_left_reg  <= skip_left_next;
            end
        end
    end

    // While the prefix is dropped, no parsing has started
    a_prefix_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (skip_left_reg != 4'd0) |-> (state_reg == dgt_pkg::ST_SPACE && !error_seen_reg))
        else $error("parse state moved during prefix");

    // A mid-header error is sticky for the following byte
    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && !in_last && res.role == dgt_pkg::ROLE_ERR) |=> error_seen_reg)
        else $error("error flag not kept");

    // Acceptance only at the end of a header without error
    a_ok_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && res.header_ok) |-> (!error_seen_reg && res.role != dgt_pkg::ROLE_ERR))
        else $error("header accepted after an error");

endmodule

/* rtl/digest_directive_tokenizer.sv */
// Digest authorization header tokenizer, top level: input register,
// parser and result register. Depends on dgt_pkg and dgt_parser.
//
// Takes one header byte per transfer and returns one result per byte, at a
// sustained rate of one byte per clock cycle while results are taken. A byte
// taken is held in the input register and classified combinationally, and
// its result is loaded into the result register, from which it is offered;
// a stalled result holds both registers. The whole parse step is a single
// state update between the input register and the result register. The
// first prefix_skip bytes of each header (default 7, "Digest ") are dropped
// unchecked. Write prefix_skip only while no header is in progress; the value
// takes effect at the start of the header that follows the next last byte
// (after reset, 7 holds for the first header).
module digest_directive_tokenizer (
    input  logic        aclk,
    input  logic        aresetn,

    // Input bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] header_byte
    input  logic        s_tlast,    // last_byte

    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] out_byte, [8] pair_done, [9] header_ok
    output logic [1:0]  m_tuser,    // [1:0] byte_role
    output logic        m_tlast,    // header_done

    // Configuration: prefix_skip
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);

    logic                 s1_valid_reg;
    logic [7:0]           s1_byte_reg;
    logic                 s1_last_reg;
    logic                 m_valid_reg;
    dgt_pkg::dgt_result_t m_res_reg;
    logic [3:0]           prefix_skip_reg;

    logic                 out_free;
    logic                 adv;
    logic                 s_accept;
    dgt_pkg::dgt_result_t res;

    assign out_free  = !m_valid_reg || m_tready;
    assign adv       = s1_valid_reg && out_free;
    assign s_tready  = !s1_valid_reg || out_free;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_skip_reg <= dgt_pkg::SKIP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            prefix_skip_reg <= cfg_data;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (adv) begin
            s1_valid_reg <= 1'b0;
        end
        if (s_accept) begin
            s1_byte_reg <= s_tdata;
            s1_last_reg <= s_tlast;
        end
    end

    dgt_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .in_byte     (s1_byte_reg),
        .in_last     (s1_last_reg),
        .prefix_skip (prefix_skip_reg),
        .res         (res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (adv) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_res_reg.header_ok, m_res_reg.pair_done, m_res_reg.data};
    assign m_tuser  = m_res_reg.role;
    assign m_tlast  = m_res_reg.header_done;

    // A verdict of ok appears only on the closing result of a header
    a_ok_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_res_reg.header_ok) |-> m_res_reg.header_done)
        else $error("header_ok without header_done");

    // Data byte is passed only for name and value characters
    a_data_role: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_res_reg.role == dgt_pkg::ROLE_SEP ||
                         m_res_reg.role == dgt_pkg::ROLE_ERR)) |-> (m_res_reg.data == 8'd0))
        else $error("data byte on separator or error");

    // A held result is not overwritten by a new one
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !adv)
        else $error("result register overwritten");

endmodule
